/* src/pnsm_pkg.sv */
`timescale 1ns / 1ps
package pnsm_pkg;

   localparam int NODES          = 8;
   localparam int ENVELOPE_BYTES = 4;
   localparam int HEADER_BYTES   = 24;

   localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int MAC_W  = 48;
   localparam int SEQ_W  = 64;
   localparam int LEN_W  = 11;
   localparam int CNT_W  = 32;
   localparam int SLOT_W = 3;
   localparam int CSR_W  = 8;
   localparam int CSR_IDX_W = 2;

   // shortest data frame that still carries the full frame header
   localparam int MIN_DATA_LEN = ENVELOPE_BYTES + HEADER_BYTES;

   typedef enum logic [3:0] {
      ST_TOO_SHORT  = 4'd0,
      ST_BAD_HEADER = 4'd1,
      ST_TABLE_FULL = 4'd2,
      ST_SHORT_DATA = 4'd3,
      ST_IN_ORDER   = 4'd4,
      ST_GAP        = 4'd5,
      ST_DUPLICATE  = 4'd6,
      ST_RESTART    = 4'd7,
      ST_OTHER_TYPE = 4'd8
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAGIC_FIRST  = 2'd0,
      CSR_MAGIC_SECOND = 2'd1,
      CSR_VERSION      = 2'd2,
      CSR_DATA_TYPE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      status_type        status;
      logic [CNT_W-1:0]  gap;
   } seq_class_type;

endpackage

/* src/pnsm_seq_unit.sv */
`timescale 1ns / 1ps
module pnsm_seq_unit (
   input  logic                       clock,
   input  logic [pnsm_pkg::SEQ_W-1:0] seq_number,
   input  logic [pnsm_pkg::SEQ_W-1:0] last_sequence,
   output pnsm_pkg::seq_class_type    result
);
   import pnsm_pkg::*;

   logic [SEQ_W-1:0] next_ff;
   logic [SEQ_W-1:0] last_ff;
   seq_class_type    result_ff;
   seq_class_type    result_in;

   // stage two: one wide compare against last + 1, gap taken from the low word
   always_comb begin
      result_in.gap = '0;
      priority if (seq_number == next_ff) begin
         result_in.status = ST_IN_ORDER;
      end else if (seq_number > next_ff) begin
         result_in.status = ST_GAP;
         result_in.gap    = seq_number[CNT_W-1:0] - next_ff[CNT_W-1:0];
      end else if (seq_number == last_ff) begin
         result_in.status = ST_DUPLICATE;
      end else begin
         result_in.status = ST_RESTART;
      end
   end

   // free running: the sequencer holds its operands steady until the registered result is taken
   always_ff @(posedge clock) begin
      next_ff   <= last_sequence + SEQ_W'(1);
      last_ff   <= last_sequence;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

/* src/per_node_sequence_monitor_top.sv */
`timescale 1ns / 1ps
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// req      | req_valid / req_stall | src_mac, hdr bytes, type, length, seq
// rsp      | rsp_valid / rsp_stall | status, slot, gap_added, totals
// csr      | csr_we                | csr_index, csr_wdata (8 bits)
//
// one beat at a time: a short or bad header packet goes from the check straight
// to the result; otherwise the source table is scanned, one slot a cycle through
// a single address comparator, and a data frame after the first from its source
// is classed by the shared 64-bit sequence unit.
// reset (synchronous) empties the source table and clears the unknown count.
// req_stall is high while a beat is in work; a stalled result holds in the
// output register, and the next beat is taken once the result is loaded there.
module per_node_sequence_monitor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pnsm_pkg::MAC_W-1:0]     req_src_mac,
   input  logic [7:0]                     req_hdr_byte0,
   input  logic [7:0]                     req_hdr_byte1,
   input  logic [7:0]                     req_hdr_version,
   input  logic [7:0]                     req_packet_type,
   input  logic [pnsm_pkg::LEN_W-1:0]     req_packet_length,
   input  logic [pnsm_pkg::SEQ_W-1:0]     req_seq_number,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [3:0]                     rsp_status,
   output logic [pnsm_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [pnsm_pkg::CNT_W-1:0]     rsp_gap_added,
   output logic [pnsm_pkg::CNT_W-1:0]     rsp_gaps_total,
   output logic [pnsm_pkg::CNT_W-1:0]     rsp_duplicates_total,
   output logic [pnsm_pkg::CNT_W-1:0]     rsp_restarts_total,
   output logic [pnsm_pkg::CNT_W-1:0]     rsp_data_frames_total,
   output logic [pnsm_pkg::CNT_W-1:0]     rsp_bytes_total,
   output logic [pnsm_pkg::CNT_W-1:0]     rsp_unknown_total,
   input  logic                           csr_we,
   input  logic [pnsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pnsm_pkg::CSR_W-1:0]     csr_wdata
);
   import pnsm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_ACCUM,
      S_SEQ_WAIT,
      S_SEQ_APPLY,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [7:0] magic_first_ff, magic_second_ff, version_ff, data_type_ff;

   logic [MAC_W-1:0] mac_ff;
   logic [7:0]       hdr0_ff, hdr1_ff, hdr_ver_ff, type_ff;
   logic [LEN_W-1:0] len_ff;
   logic [SEQ_W-1:0] seq_ff;

   logic [NODES-1:0] slot_in_use_ff;
   logic [NODES-1:0] seen_ff;
   logic [MAC_W-1:0] slot_address_ff [NODES];
   logic [SEQ_W-1:0] prev_seq_ff     [NODES];
   logic [CNT_W-1:0] gap_cnt_ff      [NODES];
   logic [CNT_W-1:0] dup_cnt_ff      [NODES];
   logic [CNT_W-1:0] restart_cnt_ff  [NODES];
   logic [CNT_W-1:0] frame_cnt_ff    [NODES];
   logic [CNT_W-1:0] byte_cnt_ff     [NODES];
   logic [CNT_W-1:0] unknown_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic             free_found_ff;
   logic             has_slot_ff;
   status_type       status_ff;
   logic [CNT_W-1:0] gap_ff;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [CNT_W-1:0] rsp_gap_ff, rsp_gaps_ff, rsp_dups_ff, rsp_restarts_ff;
   logic [CNT_W-1:0] rsp_frames_ff, rsp_bytes_ff, rsp_unknown_ff;

   logic             hit;
   logic             free_here;
   logic             last_idx;
   logic [IDX_W-1:0] alloc_idx;
   seq_class_type    seq_result;

   pnsm_seq_unit u_seq (
      .clock         (clock),
      .seq_number    (seq_ff),
      .last_sequence (prev_seq_ff[idx_ff]),
      .result        (seq_result)
   );

   assign hit       = slot_in_use_ff[idx_ff] && (slot_address_ff[idx_ff] == mac_ff);
   assign free_here = !slot_in_use_ff[idx_ff];
   assign last_idx  = (idx_ff == IDX_W'(NODES - 1));
   assign alloc_idx = free_found_ff ? free_idx_ff : idx_ff;

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         slot_in_use_ff  <= '0;
         unknown_ff      <= '0;
         magic_first_ff  <= '0;
         magic_second_ff <= '0;
         version_ff      <= '0;
         data_type_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_MAGIC_FIRST:  magic_first_ff  <= csr_wdata;
               CSR_MAGIC_SECOND: magic_second_ff <= csr_wdata;
               CSR_VERSION:      version_ff      <= csr_wdata;
               CSR_DATA_TYPE:    data_type_ff    <= csr_wdata;
               default:          ;
            endcase
         end

         // the completion state reloads the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mac_ff     <= req_src_mac;
                  hdr0_ff    <= req_hdr_byte0;
                  hdr1_ff    <= req_hdr_byte1;
                  hdr_ver_ff <= req_hdr_version;
                  type_ff    <= req_packet_type;
                  len_ff     <= req_packet_length;
                  seq_ff     <= req_seq_number;
                  state_ff   <= S_CHECK;
               end
            end
            S_CHECK: begin
               has_slot_ff   <= 1'b0;
               gap_ff        <= '0;
               idx_ff        <= '0;
               free_found_ff <= 1'b0;
               priority if (len_ff < LEN_W'(ENVELOPE_BYTES)) begin
                  status_ff <= ST_TOO_SHORT;
                  state_ff  <= S_DONE;
               end else if (hdr0_ff != magic_first_ff || hdr1_ff != magic_second_ff ||
                            hdr_ver_ff != version_ff) begin
                  unknown_ff <= unknown_ff + CNT_W'(1);
                  status_ff  <= ST_BAD_HEADER;
                  state_ff   <= S_DONE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               priority if (hit) begin
                  has_slot_ff <= 1'b1;
                  state_ff    <= S_ACCUM;
               end else if (last_idx) begin
                  if (free_found_ff || free_here) begin
                     // claim the first free slot and clear its counters
                     slot_in_use_ff[alloc_idx]  <= 1'b1;
                     slot_address_ff[alloc_idx] <= mac_ff;
                     seen_ff[alloc_idx]         <= 1'b0;
                     gap_cnt_ff[alloc_idx]      <= '0;
                     dup_cnt_ff[alloc_idx]      <= '0;
                     restart_cnt_ff[alloc_idx]  <= '0;
                     frame_cnt_ff[alloc_idx]    <= '0;
                     byte_cnt_ff[alloc_idx]     <= '0;
                     idx_ff                     <= alloc_idx;
                     has_slot_ff                <= 1'b1;
                     state_ff                   <= S_ACCUM;
                  end else begin
                     unknown_ff <= unknown_ff + CNT_W'(1);
                     status_ff  <= ST_TABLE_FULL;
                     state_ff   <= S_DONE;
                  end
               end else begin
                  if (free_here && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= idx_ff;
                  end
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_ACCUM: begin
               byte_cnt_ff[idx_ff] <= byte_cnt_ff[idx_ff] + CNT_W'(len_ff);
               priority if (type_ff != data_type_ff) begin
                  status_ff <= ST_OTHER_TYPE;
                  state_ff  <= S_DONE;
               end else if (len_ff < LEN_W'(MIN_DATA_LEN)) begin
                  unknown_ff <= unknown_ff + CNT_W'(1);
                  status_ff  <= ST_SHORT_DATA;
                  state_ff   <= S_DONE;
               end else begin
                  frame_cnt_ff[idx_ff] <= frame_cnt_ff[idx_ff] + CNT_W'(1);
                  if (!seen_ff[idx_ff]) begin
                     prev_seq_ff[idx_ff] <= seq_ff;
                     seen_ff[idx_ff]     <= 1'b1;
                     status_ff           <= ST_IN_ORDER;
                     state_ff            <= S_DONE;
                  end else begin
                     state_ff <= S_SEQ_WAIT;
                  end
               end
            end
            S_SEQ_WAIT: begin
               state_ff <= S_SEQ_APPLY;
            end
            S_SEQ_APPLY: begin
               status_ff <= seq_result.status;
               gap_ff    <= seq_result.gap;
               unique case (seq_result.status)
                  ST_GAP:       gap_cnt_ff[idx_ff] <= gap_cnt_ff[idx_ff] + seq_result.gap;
                  ST_DUPLICATE: dup_cnt_ff[idx_ff] <= dup_cnt_ff[idx_ff] + CNT_W'(1);
                  ST_RESTART:   restart_cnt_ff[idx_ff] <= restart_cnt_ff[idx_ff] + CNT_W'(1);
                  default:      ;
               endcase
               prev_seq_ff[idx_ff] <= seq_ff;
               state_ff            <= S_DONE;
            end
            S_DONE: begin
               // load only when the output register is free or being emptied
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= status_ff;
                  rsp_unknown_ff <= unknown_ff;
                  if (has_slot_ff) begin
                     rsp_slot_ff     <= SLOT_W'(idx_ff);
                     rsp_gap_ff      <= gap_ff;
                     rsp_gaps_ff     <= gap_cnt_ff[idx_ff];
                     rsp_dups_ff     <= dup_cnt_ff[idx_ff];
                     rsp_restarts_ff <= restart_cnt_ff[idx_ff];
                     rsp_frames_ff   <= frame_cnt_ff[idx_ff];
                     rsp_bytes_ff    <= byte_cnt_ff[idx_ff];
                  end else begin
                     rsp_slot_ff     <= '0;
                     rsp_gap_ff      <= '0;
                     rsp_gaps_ff     <= '0;
                     rsp_dups_ff     <= '0;
                     rsp_restarts_ff <= '0;
                     rsp_frames_ff   <= '0;
                     rsp_bytes_ff    <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_gap_added         = rsp_gap_ff;
   assign rsp_gaps_total        = rsp_gaps_ff;
   assign rsp_duplicates_total  = rsp_dups_ff;
   assign rsp_restarts_total    = rsp_restarts_ff;
   assign rsp_data_frames_total = rsp_frames_ff;
   assign rsp_bytes_total       = rsp_bytes_ff;
   assign rsp_unknown_total     = rsp_unknown_ff;

   // a result beat is only ever raised out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   // results without a slot carry no per-slot figures
   a_no_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_TOO_SHORT || rsp_status_ff == ST_BAD_HEADER ||
                        rsp_status_ff == ST_TABLE_FULL))
      |-> (rsp_slot_ff == '0 && rsp_bytes_ff == '0 && rsp_gap_ff == '0))
      else $error("per-slot totals on a slotless result");

   // the unknown count never moves while no beat is in work
   a_unknown_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(unknown_ff))
      else $error("unknown count moved while idle");

   // sequence classing only runs on a source that already has a last sequence
   a_seq_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEQ_APPLY) |-> (seen_ff[idx_ff] && slot_in_use_ff[idx_ff]))
      else $error("sequence classed without history");

   // slots are never released outside reset
   a_slots_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((slot_in_use_ff & $past(slot_in_use_ff)) == $past(slot_in_use_ff)))
      else $error("slot released");

endmodule

/* bench/sequence_monitor_checker.sv */
`timescale 1ns / 1ps
module sequence_monitor_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [pnsm_pkg::MAC_W-1:0]     req_src_mac,
   input  logic [7:0]                     req_hdr_byte0,
   input  logic [7:0]                     req_hdr_byte1,
   input  logic [7:0]                     req_hdr_version,
   input  logic [7:0]                     req_packet_type,
   input  logic [pnsm_pkg::LEN_W-1:0]     req_packet_length,
   input  logic [pnsm_pkg::SEQ_W-1:0]     req_seq_number,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [3:0]                     rsp_status,
   input  logic [pnsm_pkg::SLOT_W-1:0]    rsp_slot,
   input  logic [pnsm_pkg::CNT_W-1:0]     rsp_gap_added,
   input  logic [pnsm_pkg::CNT_W-1:0]     rsp_gaps_total,
   input  logic [pnsm_pkg::CNT_W-1:0]     rsp_duplicates_total,
   input  logic [pnsm_pkg::CNT_W-1:0]     rsp_restarts_total,
   input  logic [pnsm_pkg::CNT_W-1:0]     rsp_data_frames_total,
   input  logic [pnsm_pkg::CNT_W-1:0]     rsp_bytes_total,
   input  logic [pnsm_pkg::CNT_W-1:0]     rsp_unknown_total,
   input  logic                           csr_we,
   input  logic [pnsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pnsm_pkg::CSR_W-1:0]     csr_wdata,
   output int unsigned                    mismatch_count,
   output int unsigned                    pending_results,
   output int unsigned                    results_checked,
   output logic [8:0]                     status_seen
);
   import pnsm_pkg::*;

   typedef struct packed {
      status_type       status;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0] gap_added;
      logic [CNT_W-1:0] gaps;
      logic [CNT_W-1:0] duplicates;
      logic [CNT_W-1:0] restarts;
      logic [CNT_W-1:0] frames;
      logic [CNT_W-1:0] bytes;
      logic [CNT_W-1:0] unknown;
   } packet_verdict_type;

   logic [7:0]       want_magic0, want_magic1, want_version, data_kind;
   logic             source_used [NODES];
   logic [MAC_W-1:0] source_mac  [NODES];
   logic [SEQ_W-1:0] prior_seq   [NODES];
   logic             seq_valid   [NODES];
   logic [CNT_W-1:0] gap_sum     [NODES];
   logic [CNT_W-1:0] dup_sum     [NODES];
   logic [CNT_W-1:0] restart_sum [NODES];
   logic [CNT_W-1:0] frame_sum   [NODES];
   logic [CNT_W-1:0] byte_sum    [NODES];
   logic [CNT_W-1:0] unknown_sum;

   packet_verdict_type expected_verdicts[$];

   function automatic packet_verdict_type account_packet(
      input logic [MAC_W-1:0] mac, input logic [7:0] b0, b1, version, kind,
      input logic [LEN_W-1:0] length, input logic [SEQ_W-1:0] seq);
      packet_verdict_type v;
      int               s;
      logic [SEQ_W-1:0] follow_on, missing;
      v = '0;
      s = -1;
      if (length < ENVELOPE_BYTES) begin
         v.status = ST_TOO_SHORT;
      end else if (b0 != want_magic0 || b1 != want_magic1 || version != want_version) begin
         unknown_sum++;
         v.status = ST_BAD_HEADER;
      end else begin
         for (int i = 0; i < NODES; i++)
            if (s < 0 && source_used[i] && source_mac[i] == mac) s = i;
         // new source takes the lowest free entry, counters cleared
         for (int i = 0; i < NODES; i++) begin
            if (s < 0 && !source_used[i]) begin
               s = i;
               source_used[i] = 1'b1;
               source_mac[i]  = mac;
               seq_valid[i]   = 1'b0;
               gap_sum[i]     = '0;
               dup_sum[i]     = '0;
               restart_sum[i] = '0;
               frame_sum[i]   = '0;
               byte_sum[i]    = '0;
            end
         end
         if (s < 0) begin
            unknown_sum++;
            v.status = ST_TABLE_FULL;
         end else begin
            byte_sum[s] = byte_sum[s] + CNT_W'(length);
            if (kind != data_kind) begin
               v.status = ST_OTHER_TYPE;
            end else if (int'(length) - ENVELOPE_BYTES < HEADER_BYTES) begin
               unknown_sum++;
               v.status = ST_SHORT_DATA;
            end else begin
               frame_sum[s]++;
               v.status = ST_IN_ORDER;
               if (seq_valid[s]) begin
                  follow_on = prior_seq[s] + 64'd1;
                  if (seq == follow_on) begin
                     v.status = ST_IN_ORDER;
                  end else if (seq > follow_on) begin
                     missing     = seq - prior_seq[s] - 64'd1;
                     v.gap_added = missing[CNT_W-1:0];
                     gap_sum[s]  = gap_sum[s] + v.gap_added;
                     v.status    = ST_GAP;
                  end else if (seq == prior_seq[s]) begin
                     dup_sum[s]++;
                     v.status = ST_DUPLICATE;
                  end else begin
                     restart_sum[s]++;
                     v.status = ST_RESTART;
                  end
               end
               prior_seq[s] = seq;
               seq_valid[s] = 1'b1;
            end
         end
      end
      if (s >= 0) begin
         v.slot       = SLOT_W'(s);
         v.gaps       = gap_sum[s];
         v.duplicates = dup_sum[s];
         v.restarts   = restart_sum[s];
         v.frames     = frame_sum[s];
         v.bytes      = byte_sum[s];
      end
      v.unknown = unknown_sum;
      return v;
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] want, got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      packet_verdict_type want;
      if (reset) begin
         want_magic0  = '0;
         want_magic1  = '0;
         want_version = '0;
         data_kind    = '0;
         unknown_sum  = '0;
         for (int i = 0; i < NODES; i++) begin
            source_used[i] = 1'b0;
            seq_valid[i]   = 1'b0;
         end
         expected_verdicts.delete();
         status_seen = '0;
      end else begin
         // result beat first, so a packet taken on the same edge cannot be matched
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("result beat with no packet waiting: status %0d", rsp_status);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_status));
               compare_field("slot", 64'(want.slot), 64'(rsp_slot));
               compare_field("gap_added", 64'(want.gap_added), 64'(rsp_gap_added));
               compare_field("gaps_total", 64'(want.gaps), 64'(rsp_gaps_total));
               compare_field("duplicates_total", 64'(want.duplicates),
                             64'(rsp_duplicates_total));
               compare_field("restarts_total", 64'(want.restarts), 64'(rsp_restarts_total));
               compare_field("data_frames_total", 64'(want.frames),
                             64'(rsp_data_frames_total));
               compare_field("bytes_total", 64'(want.bytes), 64'(rsp_bytes_total));
               compare_field("unknown_total", 64'(want.unknown), 64'(rsp_unknown_total));
               status_seen[want.status] = 1'b1;
               results_checked++;
            end
         end
         if (req_valid && !req_stall)
            expected_verdicts.push_back(account_packet(req_src_mac, req_hdr_byte0,
               req_hdr_byte1, req_hdr_version, req_packet_type, req_packet_length,
               req_seq_number));
         if (csr_we) begin
            case (csr_index)
               CSR_MAGIC_FIRST:  want_magic0  = csr_wdata;
               CSR_MAGIC_SECOND: want_magic1  = csr_wdata;
               CSR_VERSION:      want_version = csr_wdata;
               CSR_DATA_TYPE:    data_kind    = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_results = expected_verdicts.size();
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import pnsm_pkg::*;

   localparam int RANDOM_PER_PHASE = 100;
   localparam int SETTLE_CYCLES    = NODES + 12;

   typedef struct {
      logic [MAC_W-1:0] mac;
      logic [7:0]       b0, b1, version, kind;
      logic [LEN_W-1:0] length;
      logic [SEQ_W-1:0] seq;
   } packet_beat_type;

   logic                 clock, reset;
   logic                 req_valid, req_stall;
   logic [MAC_W-1:0]     req_src_mac;
   logic [7:0]           req_hdr_byte0, req_hdr_byte1, req_hdr_version, req_packet_type;
   logic [LEN_W-1:0]     req_packet_length;
   logic [SEQ_W-1:0]     req_seq_number;
   logic                 rsp_valid, rsp_stall;
   logic [3:0]           rsp_status;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [CNT_W-1:0]     rsp_gap_added, rsp_gaps_total, rsp_duplicates_total;
   logic [CNT_W-1:0]     rsp_restarts_total, rsp_data_frames_total, rsp_bytes_total;
   logic [CNT_W-1:0]     rsp_unknown_total;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int unsigned          mismatch_count, pending_results, results_checked;
   logic [8:0]           status_seen;

   // stimulus side copy of the registers, only used to build headers
   logic [7:0]       cfg_magic0, cfg_magic1, cfg_version, cfg_kind;
   logic [MAC_W-1:0] source_pool [NODES];
   logic [SEQ_W-1:0] sent_seq    [NODES];
   int unsigned      beats_sent, settings_used;
   logic             sender_burst;

   per_node_sequence_monitor_top dut (.*);
   sequence_monitor_checker loss_check (.*);

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #1000000;
      $display("testbench failed");
      $finish;
   end

   function automatic logic [SEQ_W-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic packet_beat_type framed_packet(input logic [MAC_W-1:0] mac,
      input logic [7:0] kind, input logic [LEN_W-1:0] length, input logic [SEQ_W-1:0] seq);
      packet_beat_type p;
      p.mac     = mac;
      p.b0      = cfg_magic0;
      p.b1      = cfg_magic1;
      p.version = cfg_version;
      p.kind    = kind;
      p.length  = length;
      p.seq     = seq;
      return p;
   endfunction

   function automatic packet_beat_type random_packet();
      packet_beat_type  p;
      logic [SEQ_W-1:0] w;
      int               pick, k;
      w    = random_word();
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, NODES - 1);
      p    = framed_packet(w[MAC_W-1:0], 8'($urandom()), LEN_W'($urandom_range(0, 2047)),
                           random_word());
      if (pick < 3) begin
         p.b0      = 8'($urandom());
         p.b1      = 8'($urandom());
         p.version = 8'($urandom());
         p.length  = LEN_W'($urandom_range(0, ENVELOPE_BYTES - 1));
      end else if (pick < 10) begin
         p.length = LEN_W'($urandom_range(ENVELOPE_BYTES, 2047));
         case ($urandom_range(0, 2))
            0:       p.b0      = p.b0 ^ 8'($urandom_range(1, 255));
            1:       p.b1      = p.b1 ^ 8'($urandom_range(1, 255));
            default: p.version = p.version ^ 8'($urandom_range(1, 255));
         endcase
      end else if (pick < 15) begin
         // unseen source once the table is full
         p.length = LEN_W'($urandom_range(ENVELOPE_BYTES, 2047));
      end else begin
         p.mac = source_pool[k];
         pick  = $urandom_range(0, 99);
         if (pick < 10) begin
            p.kind   = cfg_kind ^ 8'($urandom_range(1, 255));
            p.length = LEN_W'($urandom_range(ENVELOPE_BYTES, 2047));
         end else if (pick < 18) begin
            p.kind   = cfg_kind;
            p.length = LEN_W'($urandom_range(ENVELOPE_BYTES, MIN_DATA_LEN - 1));
         end else begin
            p.kind   = cfg_kind;
            p.length = LEN_W'($urandom_range(MIN_DATA_LEN, 2047));
            pick     = $urandom_range(0, 99);
            if (pick < 50)      p.seq = sent_seq[k] + 64'd1;
            else if (pick < 62) p.seq = sent_seq[k] + 64'($urandom_range(2, 20));
            else if (pick < 70) p.seq = sent_seq[k] + w;
            else if (pick < 80) p.seq = sent_seq[k];
            else if (pick < 90) p.seq = sent_seq[k] - 64'($urandom_range(1, 1000));
            sent_seq[k] = p.seq;
         end
      end
      return p;
   endfunction

   task automatic write_register(input csr_index_type idx, input logic [7:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_MAGIC_FIRST:  cfg_magic0  = value;
         CSR_MAGIC_SECOND: cfg_magic1  = value;
         CSR_VERSION:      cfg_version = value;
         default:          cfg_kind    = value;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic program_config(input logic [7:0] m0, m1, version, kind);
      write_register(CSR_MAGIC_FIRST, m0);
      write_register(CSR_MAGIC_SECOND, m1);
      write_register(CSR_VERSION, version);
      write_register(CSR_DATA_TYPE, kind);
      settings_used++;
   endtask

   task automatic send_packet(input packet_beat_type p);
      int unsigned pause;
      if (beats_sent % 25 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      pause = sender_burst ? 0 : $urandom_range(0, 11);
      if (pause != 0) begin
         req_valid = 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_src_mac       = p.mac;
      req_hdr_byte0     = p.b0;
      req_hdr_byte1     = p.b1;
      req_hdr_version   = p.version;
      req_packet_type   = p.kind;
      req_packet_length = p.length;
      req_seq_number    = p.seq;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   // hold the sender until every result is back and the block has gone quiet
   task automatic wait_for_results();
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned hold, taken;
      logic        receiver_burst;
      rsp_stall      = 1'b1;
      taken          = 0;
      receiver_burst = 1'b0;
      @(negedge clock);
      forever begin
         if (taken % 30 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
         hold = receiver_burst ? 0 : $urandom_range(0, 11);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         taken++;
      end
   end

   initial begin
      packet_beat_type  p;
      logic [SEQ_W-1:0] wrap_seq;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_src_mac       = '0;
      req_hdr_byte0     = '0;
      req_hdr_byte1     = '0;
      req_hdr_version   = '0;
      req_packet_type   = '0;
      req_packet_length = '0;
      req_seq_number    = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      beats_sent        = 0;
      settings_used     = 0;
      sender_burst      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      source_pool[0] = '0;
      source_pool[1] = '1;
      for (int i = 2; i < NODES; i++) source_pool[i] = {16'(i), $urandom()};

      program_config(8'hA5, 8'h5A, 8'h03, 8'h10);

      // runts and broken envelopes
      p = framed_packet(MAC_W'(random_word()), cfg_kind, '0, random_word());
      send_packet(p);
      p.length = LEN_W'(ENVELOPE_BYTES - 1);
      send_packet(p);
      p = framed_packet(source_pool[0], cfg_kind, LEN_W'(2047), '0);
      p.b0 = ~cfg_magic0;
      send_packet(p);
      p = framed_packet(source_pool[0], cfg_kind, LEN_W'(2047), '0);
      p.b1 = ~cfg_magic1;
      send_packet(p);
      p = framed_packet(source_pool[0], cfg_kind, LEN_W'(2047), '0);
      p.version = ~cfg_version;
      send_packet(p);

      // one source through every sequence class, with the wrap past all ones
      send_packet(framed_packet(source_pool[0], ~cfg_kind, LEN_W'(ENVELOPE_BYTES), '1));
      send_packet(framed_packet(source_pool[0], cfg_kind, LEN_W'(MIN_DATA_LEN - 1), '1));
      send_packet(framed_packet(source_pool[0], cfg_kind, LEN_W'(MIN_DATA_LEN), '1));
      send_packet(framed_packet(source_pool[0], cfg_kind, LEN_W'(MIN_DATA_LEN), '0));
      send_packet(framed_packet(source_pool[0], cfg_kind, LEN_W'(MIN_DATA_LEN), '0));
      send_packet(framed_packet(source_pool[0], cfg_kind, LEN_W'(MIN_DATA_LEN), 64'd100));
      send_packet(framed_packet(source_pool[0], cfg_kind, LEN_W'(MIN_DATA_LEN), 64'd50));
      // gap wider than the counter
      wrap_seq = 64'd50 + (64'd1 << 40) + 64'd7;
      send_packet(framed_packet(source_pool[0], cfg_kind, LEN_W'(MIN_DATA_LEN), wrap_seq));
      sent_seq[0] = wrap_seq;

      // last at all ones makes a repeat of it count as a full-width gap
      send_packet(framed_packet(source_pool[1], cfg_kind, LEN_W'(2047), '1));
      send_packet(framed_packet(source_pool[1], cfg_kind, LEN_W'(2047), '1));
      sent_seq[1] = '1;

      for (int i = 2; i < NODES; i++) begin
         sent_seq[i] = random_word();
         send_packet(framed_packet(source_pool[i], cfg_kind,
                                   LEN_W'($urandom_range(MIN_DATA_LEN, 2047)), sent_seq[i]));
      end
      send_packet(framed_packet(MAC_W'(random_word()), cfg_kind, LEN_W'(2047), random_word()));
      send_packet(framed_packet(source_pool[1], 8'hFF, LEN_W'(2047), '0));

      for (int phase = 0; phase < 4; phase++) begin
         wait_for_results();
         case (phase)
            0:       program_config(8'h00, 8'h00, 8'h00, 8'h00);
            1:       program_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            default: program_config(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                    8'($urandom()));
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 1 && n == RANDOM_PER_PHASE / 2) wait_for_results();
            send_packet(random_packet());
         end
      end

      wait_for_results();
      $display("covered %0d packets under %0d register settings, %0d results compared",
               beats_sent, settings_used, results_checked);
      $display("status codes returned (bit per code, 8 down to 0): %b", status_seen);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* per_node_sequence_monitor_top.f */
src/pnsm_pkg.sv
src/pnsm_seq_unit.sv
src/per_node_sequence_monitor_top.sv
bench/sequence_monitor_checker.sv
bench/testbench.sv
